// ===== sv/jsu_pkg.sv =====
// jsu_pkg: shared types, codes and helpers for the JSON string unescaper.
// No dependencies; imported by jsu_decode and json_string_unescape_top.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ErrW  = 3;

  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash  = 8'h2F;
  localparam logic [ByteW-1:0] CtrlMax  = 8'h1F;
  localparam logic [ByteW-1:0] ChLowB   = 8'h62;
  localparam logic [ByteW-1:0] ChLowF   = 8'h66;
  localparam logic [ByteW-1:0] ChLowN   = 8'h6E;
  localparam logic [ByteW-1:0] ChLowR   = 8'h72;
  localparam logic [ByteW-1:0] ChLowT   = 8'h74;
  localparam logic [ByteW-1:0] ChLowU   = 8'h75;
  localparam logic [ByteW-1:0] ChBs     = 8'h08;
  localparam logic [ByteW-1:0] ChFf     = 8'h0C;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChNul    = 8'h00;

  typedef enum logic [7:0] {
    ModeIdle = 8'b0000_0001,
    ModeBody = 8'b0000_0010,
    ModeEsc  = 8'b0000_0100,
    ModeHex1 = 8'b0000_1000,
    ModeHex2 = 8'b0001_0000,
    ModeHex3 = 8'b0010_0000,
    ModeHex4 = 8'b0100_0000,
    ModeHalt = 8'b1000_0000
  } mode_e;

  typedef enum logic [ErrW-1:0] {
    ErrNone     = 3'd0,
    ErrEofEsc   = 3'd1,
    ErrEofHex   = 3'd2,
    ErrBadHex   = 3'd3,
    ErrBadEsc   = 3'd4,
    ErrCtrl     = 3'd5,
    ErrUnclosed = 3'd6
  } err_e;

  typedef struct packed {
    logic             char_valid;
    logic [ByteW-1:0] char_out;
    logic             closed;
    logic [ErrW-1:0]  error_code;
  } res_t;

  function automatic logic is_hex(logic [ByteW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

endpackage

// ===== sv/jsu_decode.sv =====
// jsu_decode: scan mode and held error registers plus the per-byte decode.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [jsu_pkg::ByteW-1:0] byte_i,
  input  logic                      start_i,
  output jsu_pkg::res_t             res_o
);
  import jsu_pkg::*;

  mode_e mode_q, mode_d, mode_cur;
  err_e  held_q, held_d, held_cur;
  res_t  res;

  always_comb begin
    mode_cur = start_i ? ModeBody : mode_q;
    held_cur = start_i ? ErrNone : held_q;
    mode_d   = mode_cur;
    held_d   = held_cur;
    res      = '0;
    case (mode_cur)
      ModeBody: begin
        if (byte_i == ChNul) begin
          mode_d = ModeHalt;
          held_d = ErrUnclosed;
        end else if (byte_i == ChQuote) begin
          res.closed = 1'b1;
          mode_d     = ModeIdle;
        end else if (byte_i == ChBslash) begin
          mode_d = ModeEsc;
        end else if (byte_i <= CtrlMax) begin
          mode_d = ModeHalt;
          held_d = ErrCtrl;
        end else begin
          res.char_valid = 1'b1;
          res.char_out   = byte_i;
        end
      end
      ModeEsc: begin
        mode_d         = ModeBody;
        res.char_valid = 1'b1;
        case (byte_i)
          ChNul: begin
            res.char_valid = 1'b0;
            mode_d         = ModeHalt;
            held_d         = ErrEofEsc;
          end
          ChQuote, ChBslash, ChSlash: res.char_out = byte_i;
          ChLowB: res.char_out = ChBs;
          ChLowF: res.char_out = ChFf;
          ChLowN: res.char_out = ChLf;
          ChLowR: res.char_out = ChCr;
          ChLowT: res.char_out = ChTab;
          ChLowU: begin
            res.char_valid = 1'b0;
            mode_d         = ModeHex1;
          end
          default: begin
            res.char_valid = 1'b0;
            mode_d         = ModeHalt;
            held_d         = ErrBadEsc;
          end
        endcase
      end
      ModeHex1, ModeHex2, ModeHex3, ModeHex4: begin
        if (byte_i == ChNul) begin
          mode_d = ModeHalt;
          held_d = ErrEofHex;
        end else if (!is_hex(byte_i)) begin
          mode_d = ModeHalt;
          held_d = ErrBadHex;
        end else begin
          case (mode_cur)
            ModeHex1: mode_d = ModeHex2;
            ModeHex2: mode_d = ModeHex3;
            ModeHex3: mode_d = ModeHex4;
            default:  mode_d = ModeBody;
          endcase
        end
      end
      ModeHalt: begin
        res.error_code = held_cur;
      end
      default: begin
      end
    endcase
    if (mode_d == ModeHalt && mode_cur != ModeHalt) begin
      res.error_code = held_d;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      held_q <= ErrNone;
    end else if (step_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

endmodule

// ===== sv/json_string_unescape_top.sv =====
// json_string_unescape_top: input register, jsu_decode, result register.
// Depends on jsu_pkg and jsu_decode.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, byte_in_i, start_req_i | input
//   out     | out_valid_o/out_ready_i, char_valid_o, char_out_o, closed_o,
//           | error_code_o                              | output
//
// One item per cycle unless the output stalls; each item gives one result.
// The decode step runs when the input register moves into the result register.
// Reset clears both stage valids and returns the scan to idle with no error.
// A stalled result holds the result register; the input register still takes
// an item while it is empty or while the result register is free or drained.
`timescale 1ns / 1ps

module json_string_unescape_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [jsu_pkg::ByteW-1:0] byte_in_i,
  input  logic                      start_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      char_valid_o,
  output logic [jsu_pkg::ByteW-1:0] char_out_o,
  output logic                      closed_o,
  output logic [jsu_pkg::ErrW-1:0]  error_code_o
);
  import jsu_pkg::*;

  logic             in_vld_q;
  logic [ByteW-1:0] byte_q;
  logic             start_q;
  logic             out_vld_q;
  res_t             res_q, res_d;
  logic             out_free;
  logic             step;

  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .start_i(start_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= byte_in_i;
      start_q <= start_req_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign char_valid_o = res_q.char_valid;
  assign char_out_o   = res_q.char_out;
  assign closed_o     = res_q.closed;
  assign error_code_o = res_q.error_code;

endmodule
